[hdl/s2a_pkg.sv]
// Shared types, constants and lookup tables for the scancode to ASCII block.
// No dependencies; every module of the block imports this package.
package s2a_pkg;

  localparam int RING_DEPTH = 256;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CHAR_W     = 7;
  localparam int CODE_W     = 8;
  localparam int MAP_SIZE   = 58;

  localparam logic [CODE_W-1:0] LSHIFT_CODE = 8'h2A;
  localparam logic [CODE_W-1:0] RSHIFT_CODE = 8'h36;
  localparam logic [CODE_W-1:0] CAPS_CODE   = 8'h3A;

  // US layout, set 1, make codes 0x00..0x39; zero marks a key with no character
  localparam logic [CHAR_W-1:0] US_MAP [MAP_SIZE] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  // shifted forms of '0'..'9'
  localparam logic [CHAR_W-1:0] DIGIT_SHIFTED [10] = '{
    7'h29, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28
  };

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PUSH = 2'd1,
    OP_POP  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CHAR_W-1:0] ch;
  } op_t;

  function automatic logic [CHAR_W-1:0] shifted_form(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 7'h61 && c <= 7'h7A) begin
      r = c - 7'h20;
    end else if (c >= 7'h30 && c <= 7'h39) begin
      r = DIGIT_SHIFTED[c[3:0]];
    end else begin
      case (c)
        7'h2D:   r = 7'h5F;
        7'h3D:   r = 7'h2B;
        7'h5B:   r = 7'h7B;
        7'h5D:   r = 7'h7D;
        7'h3B:   r = 7'h3A;
        7'h27:   r = 7'h22;
        7'h60:   r = 7'h7E;
        7'h5C:   r = 7'h7C;
        7'h2C:   r = 7'h3C;
        7'h2E:   r = 7'h3E;
        7'h2F:   r = 7'h3F;
        default: r = c;
      endcase
    end
    return r;
  endfunction

  function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] p);
    logic [RING_AW-1:0] r;
    if (p == RING_AW'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + RING_AW'(1);
    end
    return r;
  endfunction

endpackage

[hdl/s2a_front.sv]
// Front end: accepts requests, tracks shift and caps lock, maps make codes.
// Emits one ring operation per request. Depends on s2a_pkg.
module s2a_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic [s2a_pkg::CODE_W-1:0] in_scancode,
  output logic                      op_valid,
  input  logic                      op_ready,
  output s2a_pkg::op_t              op
);
  import s2a_pkg::*;

  logic              shift_r, shift_nxt;
  logic              caps_r, caps_nxt;
  logic              accept;
  logic [CHAR_W-1:0] mapped;
  logic [CHAR_W-1:0] ch;

  assign in_ready = op_ready;
  assign op_valid = in_valid;
  assign accept   = in_valid && op_ready;

  always_comb begin
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    op.kind   = OP_NONE;
    op.ch     = '0;
    mapped    = US_MAP[in_scancode[5:0]];
    ch        = (shift_r || caps_r) ? shifted_form(mapped) : mapped;
    if (in_req_type) begin
      op.kind = OP_POP;
    end else if (in_scancode[7]) begin
      // only the shift breaks matter
      if ({1'b0, in_scancode[6:0]} == LSHIFT_CODE ||
          {1'b0, in_scancode[6:0]} == RSHIFT_CODE) begin
        shift_nxt = 1'b0;
      end
    end else if (in_scancode == LSHIFT_CODE || in_scancode == RSHIFT_CODE) begin
      shift_nxt = 1'b1;
    end else if (in_scancode == CAPS_CODE) begin
      caps_nxt = !caps_r;
    end else if (in_scancode < CODE_W'(MAP_SIZE) && ch != '0) begin
      op.kind = OP_PUSH;
      op.ch   = ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      caps_r  <= 1'b0;
    end else if (accept) begin
      shift_r <= shift_nxt;
      caps_r  <= caps_nxt;
    end
  end

endmodule

[hdl/s2a_queue.sv]
// Two-entry queue of ring operations between front end and ring back end.
// Depends on s2a_pkg for the operation type.
module s2a_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  s2a_pkg::op_t wr_op,
  output logic         rd_valid,
  input  logic         rd_ready,
  output s2a_pkg::op_t rd_op
);
  import s2a_pkg::*;

  op_t        slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_op    = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_op;
    end
  end

endmodule

[hdl/s2a_back.sv]
// Back end: character ring memory, its write and read positions, result register.
// Executes one queued op per cycle unless the receiver stalls. Depends on s2a_pkg.
module s2a_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       op_valid,
  output logic                       op_ready,
  input  s2a_pkg::op_t               op,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [s2a_pkg::CHAR_W-1:0] out_read_char,
  output logic                       out_has_data
);
  import s2a_pkg::*;

  logic [CHAR_W-1:0]  ring_mem [RING_DEPTH];
  logic [CHAR_W-1:0]  rdata_r;
  logic [RING_AW-1:0] wp_r, wp_nxt;
  logic [RING_AW-1:0] rp_r, rp_nxt;
  logic               ob_valid_r, ob_valid_nxt;
  logic               ob_hit_r;
  logic               ob_has_r;
  logic               fire, is_push, pop_hit;

  assign op_ready = !ob_valid_r || out_ready;
  assign fire     = op_valid && op_ready;
  assign is_push  = fire && (op.kind == OP_PUSH);
  assign pop_hit  = fire && (op.kind == OP_POP) && (wp_r != rp_r);

  always_comb begin
    wp_nxt = is_push ? ring_inc(wp_r) : wp_r;
    rp_nxt = pop_hit ? ring_inc(rp_r) : rp_r;
    if (fire) begin
      ob_valid_nxt = 1'b1;
    end else if (out_ready) begin
      ob_valid_nxt = 1'b0;
    end else begin
      ob_valid_nxt = ob_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      rp_r       <= '0;
      ob_valid_r <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      ob_valid_r <= ob_valid_nxt;
    end
  end

  // result payload; hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (fire) begin
      ob_hit_r <= pop_hit;
      ob_has_r <= (wp_nxt != rp_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (is_push) begin
      ring_mem[wp_r] <= op.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_hit) begin
      rdata_r <= ring_mem[rp_r];
    end
  end

  assign out_valid     = ob_valid_r;
  assign out_read_char = ob_hit_r ? rdata_r : '0;
  assign out_has_data  = ob_has_r;

endmodule

[hdl/scancode_to_ascii_fifo.sv]
// Set-1 scancode to ASCII decoder with a character ring.
// Top level: front end, operation queue, ring back end. Depends on s2a_pkg.
//
// Input channel (in_valid/in_ready): in_req_type 0 carries a keyboard scancode
// in in_scancode, in_req_type 1 asks to read one character.
// Result channel (out_valid/out_ready): exactly one result per request, in
// request order. out_read_char is the character popped by a read, 0 when the
// ring is empty or for a scancode; out_has_data tells whether characters remain.
// Path: the request waits in the operation queue, then its result is registered.
// Throughput: one request per cycle while the receiver takes results, set by the
// single ring memory port pair (one write or one registered read per cycle).
// Reset: shift and caps lock clear, the ring is empty; ring contents are not
// cleared, so no clearing pass is needed.
// Receiver stall: the result register holds; the two-entry queue keeps taking
// requests until full, then in_ready drops.
// The ring has no full check: the 256th unread character makes it look empty.
module scancode_to_ascii_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_req_type,
  input  logic [s2a_pkg::CODE_W-1:0] in_scancode,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [s2a_pkg::CHAR_W-1:0] out_read_char,
  output logic                       out_has_data
);
  import s2a_pkg::*;

  logic fq_valid, fq_ready;
  op_t  fq_op;
  logic qb_valid, qb_ready;
  op_t  qb_op;

  s2a_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_scancode (in_scancode),
    .op_valid    (fq_valid),
    .op_ready    (fq_ready),
    .op          (fq_op)
  );

  s2a_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_op    (fq_op),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_op    (qb_op)
  );

  s2a_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .op_valid      (qb_valid),
    .op_ready      (qb_ready),
    .op            (qb_op),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_char (out_read_char),
    .out_has_data  (out_has_data)
  );

endmodule
